// ===== rtl/core/of10_match_wildcard_unpack_top_assert.svh =====
// Assertion macros for the OpenFlow 1.0 match wildcard decoder.
`ifndef OF10_MATCH_WILDCARD_UNPACK_TOP_ASSERT_SVH
`define OF10_MATCH_WILDCARD_UNPACK_TOP_ASSERT_SVH

`ifndef SYNTH

`define OFWU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define OFWU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define OFWU_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define OFWU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/ofwu_pkg.sv =====
// Shared constants and types for the OpenFlow 1.0 match wildcard decoder.
package ofwu_pkg;

    // wildcard word bit positions
    localparam int unsigned WC_IN_PORT  = 0;
    localparam int unsigned WC_DL_VLAN  = 1;
    localparam int unsigned WC_DL_SRC   = 2;
    localparam int unsigned WC_DL_DST   = 3;
    localparam int unsigned WC_DL_TYPE  = 4;
    localparam int unsigned WC_IP_PROTO = 5;
    localparam int unsigned WC_TP_SRC   = 6;
    localparam int unsigned WC_TP_DST   = 7;
    localparam int unsigned WC_SRC_LSB  = 8;
    localparam int unsigned WC_DST_LSB  = 14;
    localparam int unsigned WC_CNT_W    = 6;
    localparam int unsigned WC_VLAN_PCP = 20;
    localparam int unsigned WC_NW_TOS   = 21;

    // present map bit positions
    localparam int unsigned PB_IN_PORT  = 0;
    localparam int unsigned PB_ETH_SRC  = 1;
    localparam int unsigned PB_ETH_DST  = 2;
    localparam int unsigned PB_VLAN_VID = 3;
    localparam int unsigned PB_VLAN_PCP = 4;
    localparam int unsigned PB_ETH_TYPE = 5;
    localparam int unsigned PB_NW_SRC   = 6;
    localparam int unsigned PB_NW_DST   = 7;
    localparam int unsigned PB_NW_TOS   = 8;
    localparam int unsigned PB_IP_PROTO = 9;
    localparam int unsigned PB_TP_SRC   = 10;
    localparam int unsigned PB_TP_DST   = 11;
    localparam int unsigned PB_W        = 12;

    localparam logic [15:0] VLAN_NONE    = 16'hffff;
    localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
    localparam logic [15:0] ETYPE_ARP    = 16'h0806;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;
    localparam logic [7:0]  PROTO_ICMP   = 8'd1;

    typedef struct packed {
        logic [PB_W-1:0] present;
        logic [31:0]     src_mask;
        logic [31:0]     dst_mask;
    } result_t;

endpackage

// ===== rtl/core/ofwu_decode.sv =====
// Combinational decode of one match header into present map and prefix masks.
module ofwu_decode
(
    input  logic [31:0]      wildcard_bits,
    input  logic [15:0]      vlan_id,
    input  logic [15:0]      ether_type,
    input  logic [7:0]       ip_protocol,
    output ofwu_pkg::result_t result
);

    logic [ofwu_pkg::WC_CNT_W-1:0] src_cnt;
    logic [ofwu_pkg::WC_CNT_W-1:0] dst_cnt;
    logic                          is_ip;
    logic                          is_arp;
    logic                          type_ok;
    logic                          net_ok;
    logic                          proto_ok;
    logic                          port_ok;
    logic [ofwu_pkg::PB_W-1:0]     pb;

    assign src_cnt = wildcard_bits[ofwu_pkg::WC_SRC_LSB +: ofwu_pkg::WC_CNT_W];
    assign dst_cnt = wildcard_bits[ofwu_pkg::WC_DST_LSB +: ofwu_pkg::WC_CNT_W];

    assign type_ok  = !wildcard_bits[ofwu_pkg::WC_DL_TYPE];
    assign is_ip    = type_ok && (ether_type == ofwu_pkg::ETYPE_IPV4);
    assign is_arp   = type_ok && (ether_type == ofwu_pkg::ETYPE_ARP);
    assign net_ok   = is_ip || is_arp;
    assign proto_ok = !wildcard_bits[ofwu_pkg::WC_IP_PROTO];
    assign port_ok  = is_ip && proto_ok &&
                      ((ip_protocol == ofwu_pkg::PROTO_TCP) ||
                       (ip_protocol == ofwu_pkg::PROTO_UDP) ||
                       (ip_protocol == ofwu_pkg::PROTO_ICMP));

    always_comb
    begin
        pb = '0;
        pb[ofwu_pkg::PB_IN_PORT]  = !wildcard_bits[ofwu_pkg::WC_IN_PORT];
        pb[ofwu_pkg::PB_ETH_SRC]  = !wildcard_bits[ofwu_pkg::WC_DL_SRC];
        pb[ofwu_pkg::PB_ETH_DST]  = !wildcard_bits[ofwu_pkg::WC_DL_DST];
        pb[ofwu_pkg::PB_VLAN_VID] = !wildcard_bits[ofwu_pkg::WC_DL_VLAN];
        pb[ofwu_pkg::PB_VLAN_PCP] = !wildcard_bits[ofwu_pkg::WC_VLAN_PCP] &&
                                    !wildcard_bits[ofwu_pkg::WC_DL_VLAN] &&
                                    (vlan_id != ofwu_pkg::VLAN_NONE);
        pb[ofwu_pkg::PB_ETH_TYPE] = type_ok;
        pb[ofwu_pkg::PB_NW_SRC]   = net_ok;
        pb[ofwu_pkg::PB_NW_DST]   = net_ok;
        pb[ofwu_pkg::PB_IP_PROTO] = net_ok && proto_ok;
        pb[ofwu_pkg::PB_NW_TOS]   = is_ip && !wildcard_bits[ofwu_pkg::WC_NW_TOS];
        pb[ofwu_pkg::PB_TP_SRC]   = port_ok && !wildcard_bits[ofwu_pkg::WC_TP_SRC];
        pb[ofwu_pkg::PB_TP_DST]   = port_ok && !wildcard_bits[ofwu_pkg::WC_TP_DST];
    end

    always_comb
    begin
        result.present = pb;
        // count of 32 or more (top bit set) wildcards the whole address
        if (!net_ok || src_cnt[ofwu_pkg::WC_CNT_W-1])
            result.src_mask = '0;
        else
            result.src_mask = 32'hffff_ffff << src_cnt[ofwu_pkg::WC_CNT_W-2:0];
        if (!net_ok || dst_cnt[ofwu_pkg::WC_CNT_W-1])
            result.dst_mask = '0;
        else
            result.dst_mask = 32'hffff_ffff << dst_cnt[ofwu_pkg::WC_CNT_W-2:0];
    end

endmodule

// ===== rtl/core/of10_match_wildcard_unpack_top.sv =====
// Top level of the OpenFlow 1.0 match wildcard decoder: input and result registers.
// Decodes one OpenFlow 1.0 match header (wildcards, VLAN id, ethertype, IP
// protocol) into a 12-bit present map and IPv4 source/destination prefix
// masks. One transfer is taken every cycle while item_stall is low; a result
// passes through the two-register pipeline (input register, decode logic, result
// register) to the outputs. The stall chains back from the result register so
// both stages stay full under back-pressure.
module of10_match_wildcard_unpack_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [31:0] wildcard_bits,
    input  logic [15:0] vlan_id,
    input  logic [15:0] ether_type,
    input  logic [7:0]  ip_protocol,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [11:0] present_bits,
    output logic [31:0] src_prefix_mask,
    output logic [31:0] dst_prefix_mask
);

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [31:0]        wc_reg;
    logic [15:0]        vid_reg;
    logic [15:0]        etype_reg;
    logic [7:0]         proto_reg;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    ofwu_pkg::result_t  result_reg;
    ofwu_pkg::result_t  decoded;
    logic               s1_load;
    logic               s2_load;
    logic               chk_ports_ok;
    logic               chk_src_ok;
    logic               chk_pcp_ok;

    ofwu_decode u_decode
    (
        .wildcard_bits (wc_reg),
        .vlan_id       (vid_reg),
        .ether_type    (etype_reg),
        .ip_protocol   (proto_reg),
        .result        (decoded)
    );

    assign s2_load    = s1_valid_reg && (!rsp_valid_reg || !result_stall);
    assign item_stall = s1_valid_reg && rsp_valid_reg && result_stall;
    assign s1_load    = item_valid && !item_stall;

    always_comb
    begin
        if (s1_load)
            s1_valid_next = 1'b1;
        else if (s2_load)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s2_load)
            rsp_valid_next = 1'b1;
        else if (!result_stall)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            wc_reg    <= wildcard_bits;
            vid_reg   <= vlan_id;
            etype_reg <= ether_type;
            proto_reg <= ip_protocol;
        end
        if (s2_load)
            result_reg <= decoded;
    end

    assign result_valid    = rsp_valid_reg;
    assign present_bits    = result_reg.present;
    assign src_prefix_mask = result_reg.src_mask;
    assign dst_prefix_mask = result_reg.dst_mask;

    assign chk_ports_ok = (!present_bits[ofwu_pkg::PB_TP_SRC] &&
                           !present_bits[ofwu_pkg::PB_TP_DST]) ||
                          present_bits[ofwu_pkg::PB_IP_PROTO];
    assign chk_src_ok   = (src_prefix_mask == 32'd0) || present_bits[ofwu_pkg::PB_NW_SRC];
    assign chk_pcp_ok   = !present_bits[ofwu_pkg::PB_VLAN_PCP] ||
                          present_bits[ofwu_pkg::PB_VLAN_VID];

`include "of10_match_wildcard_unpack_top_assert.svh"

    // an accepted transfer always lands in the input register
    `OFWU_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, s1_load, s1_valid_reg)
    // ports only ever present with a matched protocol
    `OFWU_ASSERT_SAME(a_ports_need_proto, clk, rst_n, result_valid, chk_ports_ok)
    // a nonzero source mask only with the source address present
    `OFWU_ASSERT_SAME(a_mask_needs_addr, clk, rst_n, result_valid, chk_src_ok)
    // PCP only with the VLAN id matched
    `OFWU_ASSERT_SAME(a_pcp_needs_vid, clk, rst_n, result_valid, chk_pcp_ok)

endmodule
